/* design/fpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam int ADDR_W  = 32;
	localparam int KEY_W   = 2 * ADDR_W;
	localparam int TIME_W  = 48;
	localparam int CFG_W   = 24;
	localparam int APB_W   = 32;
	localparam int PADDR_W = 3;

	localparam logic [CFG_W-1:0] MIN_GAP_RESET   = 24'd180000;
	localparam logic [CFG_W-1:0] TOLERANCE_RESET = 24'd1000;

	// register index, taken from paddr[2]
	localparam logic REG_MIN_GAP   = 1'b0;
	localparam logic REG_TOLERANCE = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] last_time;
		logic [TIME_W-1:0] interval;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* design/fpd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

/* design/flow_periodicity_detector.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata: src_addr, dst_addr, time_ms
// m_*       out  tvalid/tready      tdata: periodic, table_full
// apb       in   psel/penable/pwrite regs: min_gap_ms @0x0, tolerance_ms @0x4
//
// One word at a time: accept, then a key scan of the flow table at one entry
// per cycle through the single RAM port, then up to five steps on one shared
// 48-bit subtractor and a write-back, then the result register. s_tready is
// high only while idle.
// Reset empties the table through the fill count; no clearing pass is needed.
// A stalled result holds in m_tdata and the next word waits behind it.

module flow_periodicity_detector #(
	parameter int TABLE_DEPTH = fpd_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       s_tvalid,
	output      logic                       s_tready,
	input  wire logic [111:0]               s_tdata,   // src_addr, dst_addr, time_ms

	output      logic                       m_tvalid,
	input  wire logic                       m_tready,
	output      logic [7:0]                 m_tdata,   // periodic, table_full, zero pad

	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fpd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [fpd_pkg::APB_W-1:0]  pwdata,
	output      logic [fpd_pkg::APB_W-1:0]  prdata,
	output      logic                       pready
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int TW = fpd_pkg::TIME_W;

	typedef enum logic [3:0] {
		IDLE, SCAN, MISS, GAP, MINCMP, DIFF, DIFFN, TOL, UPD, RESP
	} state_t;

	state_t state_q;

	logic [fpd_pkg::CFG_W-1:0] min_gap_q, tol_q;
	logic [fpd_pkg::KEY_W-1:0] key_q;
	logic [TW-1:0]             time_q, last_q, iv_q, gap_q, d_q, newiv_q;
	logic [AW-1:0]             idx_q, pidx_q, slot_q;
	logic [CW-1:0]             fill_q;
	logic                      pend_q, done_q, per_q, full_q;
	logic                      m_per_q, m_full_q;

	// configuration port
	logic cfg_we;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			fpd_pkg::REG_MIN_GAP:   prdata = {{(fpd_pkg::APB_W-fpd_pkg::CFG_W){1'b0}}, min_gap_q};
			fpd_pkg::REG_TOLERANCE: prdata = {{(fpd_pkg::APB_W-fpd_pkg::CFG_W){1'b0}}, tol_q};
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= fpd_pkg::MIN_GAP_RESET;
			tol_q     <= fpd_pkg::TOLERANCE_RESET;
		end else if (cfg_we) begin
			if (paddr[2] == fpd_pkg::REG_MIN_GAP) begin
				min_gap_q <= pwdata[fpd_pkg::CFG_W-1:0];
			end else begin
				tol_q <= pwdata[fpd_pkg::CFG_W-1:0];
			end
		end
	end

	// flow table
	fpd_pkg::entry_t rd_entry, wr_entry;
	logic [fpd_pkg::ENTRY_W-1:0] rd_raw;
	logic [AW-1:0]               ram_addr;
	logic                        ram_we, is_full;

	assign is_full = (fill_q == CW'(TABLE_DEPTH));
	assign ram_we  = ((state_q == MISS) && !is_full) || (state_q == UPD);
	assign rd_entry = fpd_pkg::entry_t'(rd_raw);

	always_comb begin
		wr_entry.key       = key_q;
		wr_entry.last_time = time_q;
		wr_entry.interval  = (state_q == UPD) ? newiv_q : '0;
	end

	always_comb begin
		unique case (state_q)
			MISS:    ram_addr = fill_q[AW-1:0];
			UPD:     ram_addr = slot_q;
			default: ram_addr = idx_q;
		endcase
	end

	fpd_ram #(
		.WIDTH (fpd_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (wr_entry),
		.rdata (rd_raw)
	);

	// shared subtractor; bit TW is the borrow
	logic [TW-1:0] alu_a, alu_b;
	logic [TW:0]   alu_res;
	logic          borrow;

	always_comb begin
		unique case (state_q)
			GAP:     begin alu_a = time_q;                          alu_b = last_q; end
			MINCMP:  begin alu_a = {{(TW-fpd_pkg::CFG_W){1'b0}}, min_gap_q}; alu_b = gap_q; end
			DIFF:    begin alu_a = iv_q;                            alu_b = gap_q; end
			DIFFN:   begin alu_a = gap_q;                           alu_b = iv_q; end
			TOL:     begin alu_a = d_q; alu_b = {{(TW-fpd_pkg::CFG_W){1'b0}}, tol_q}; end
			default: begin alu_a = '0;                              alu_b = '0; end
		endcase
	end

	assign alu_res = {1'b0, alu_a} - {1'b0, alu_b};
	assign borrow  = alu_res[TW];

	logic m_tvalid_q;
	logic m_load;

	assign s_tready = (state_q == IDLE);
	// load the result register when it is empty or drains this cycle
	assign m_load   = (state_q == RESP) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, m_full_q, m_per_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			key_q      <= '0;
			time_q     <= '0;
			last_q     <= '0;
			iv_q       <= '0;
			gap_q      <= '0;
			d_q        <= '0;
			newiv_q    <= '0;
			idx_q      <= '0;
			pidx_q     <= '0;
			slot_q     <= '0;
			fill_q     <= '0;
			pend_q     <= 1'b0;
			done_q     <= 1'b0;
			per_q      <= 1'b0;
			full_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_per_q    <= 1'b0;
			m_full_q   <= 1'b0;
		end else begin
			if (m_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						key_q   <= {s_tdata[31:0], s_tdata[63:32]};
						time_q  <= s_tdata[111:64];
						idx_q   <= '0;
						pend_q  <= 1'b0;
						done_q  <= (fill_q == '0);
						per_q   <= 1'b0;
						full_q  <= 1'b0;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					// compare the entry read last cycle while the next read goes out
					if (pend_q && (rd_entry.key == key_q)) begin
						slot_q  <= pidx_q;
						last_q  <= rd_entry.last_time;
						iv_q    <= rd_entry.interval;
						state_q <= GAP;
					end else if (done_q && !pend_q) begin
						state_q <= MISS;
					end else begin
						pend_q <= !done_q;
						if (!done_q) begin
							pidx_q <= idx_q;
							idx_q  <= idx_q + AW'(1);
							done_q <= ((CW'(idx_q) + CW'(1)) == fill_q);
						end
					end
				end
				MISS: begin
					if (is_full) begin
						full_q <= 1'b1;
					end else begin
						fill_q <= fill_q + CW'(1);
					end
					state_q <= RESP;
				end
				GAP: begin
					// time going backwards counts as no gap
					gap_q   <= borrow ? '0 : alu_res[TW-1:0];
					state_q <= MINCMP;
				end
				MINCMP: begin
					if (!borrow) begin
						state_q <= RESP;
					end else if (iv_q == '0) begin
						newiv_q <= gap_q;
						state_q <= UPD;
					end else begin
						state_q <= DIFF;
					end
				end
				DIFF: begin
					if (borrow) begin
						state_q <= DIFFN;
					end else begin
						d_q     <= alu_res[TW-1:0];
						state_q <= TOL;
					end
				end
				DIFFN: begin
					d_q     <= alu_res[TW-1:0];
					state_q <= TOL;
				end
				TOL: begin
					per_q   <= borrow;
					newiv_q <= borrow ? iv_q : '0;
					state_q <= UPD;
				end
				UPD: begin
					state_q <= RESP;
				end
				RESP: begin
					if (m_load) begin
						m_per_q    <= per_q;
						m_full_q   <= full_q;
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != IDLE)
		else $error("accepted word did not start a lookup");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == RESP))
		else $error("result loaded outside response step");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("periodic and table_full both set");

	a_fill_grows_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> $past(state_q == MISS))
		else $error("fill count moved outside insert");
`endif

endmodule

`default_nettype wire
